// ===== rtl/lmc_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the 3x3 local maximum counter.
package lmc_pkg;

   localparam int CFG_BITS     = 11;
   localparam int IN_BITS      = 10;
   localparam int PEAK_BITS    = 20;
   localparam int COUNT_BITS   = 21;
   localparam int ROW_BITS     = 10;
   localparam int HEIGHT_BITS  = 11;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [HEIGHT_BITS-1:0] HEIGHT_LIMIT = 11'd1024;
   localparam logic [CFG_BITS-1:0]    SIZE_RESET   = 11'd10;
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX    = {COUNT_BITS{1'b1}};

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic centre;
      logic frame_end;
   } item_flags_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

   typedef struct packed {
      logic busy;
      logic held;
   } back_status_type;

endpackage

// ===== rtl/lmc_intf.sv =====
`timescale 1ns / 1ps
// Pixel request and peak count response channel interfaces.
interface lmc_req_if;
   logic                         valid;
   logic                         ready;
   logic [lmc_pkg::IN_BITS-1:0]  pixel_value;

   modport source (output valid, output pixel_value, input ready);
   modport sink   (input valid, input pixel_value, output ready);
endinterface

interface lmc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [lmc_pkg::PEAK_BITS-1:0] peak_count;

   modport source (output valid, output peak_count, input ready);
   modport sink   (input valid, input peak_count, output ready);
endinterface

// ===== rtl/lmc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts pixels, tracks raster position and classifies each pixel.
module lmc_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   lmc_req_if.sink                        req_chan,
   input  logic [lmc_pkg::CFG_BITS-1:0]   frame_width,
   input  logic [lmc_pkg::CFG_BITS-1:0]   frame_height,
   input  logic                           queue_full,
   output logic                           push,
   output logic [PIXEL_BITS-1:0]          push_pix,
   output logic [$clog2(MAX_WIDTH)-1:0]   push_slot,
   output lmc_pkg::item_flags_type        push_flags
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WB  = $clog2(MAX_WIDTH + 1);
   localparam int WW  = (WB > lmc_pkg::CFG_BITS) ? WB : lmc_pkg::CFG_BITS;
   localparam int HB  = lmc_pkg::HEIGHT_BITS;

   logic [CW-1:0]                col_ff, col_in;
   logic [lmc_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic [WW-1:0]                fw_ext, width_eff, col_plus;
   logic [HB-1:0]                height_eff, row_plus;
   logic                         row_end, frame_end, accept;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   // clamp the programmed size into the supported range
   always_comb begin
      fw_ext = WW'(frame_width);
      if (fw_ext < WW'(3)) begin
         width_eff = WW'(3);
      end else if (fw_ext > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = fw_ext;
      end
      if (frame_height < HB'(3)) begin
         height_eff = HB'(3);
      end else if (frame_height > lmc_pkg::HEIGHT_LIMIT) begin
         height_eff = lmc_pkg::HEIGHT_LIMIT;
      end else begin
         height_eff = frame_height;
      end
   end

   assign col_plus  = WW'(col_ff) + WW'(1);
   assign row_plus  = HB'(row_ff) + HB'(1);
   assign row_end   = (col_plus >= width_eff);
   assign frame_end = row_end && (row_plus >= height_eff);

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         priority if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_plus[lmc_pkg::ROW_BITS-1:0];
         end else begin
            col_in = col_plus[CW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   assign push                 = accept;
   assign push_pix             = PIXEL_BITS'(req_chan.pixel_value);
   assign push_slot            = col_ff;
   assign push_flags.centre    = (row_ff >= lmc_pkg::ROW_BITS'(2)) && (col_ff >= CW'(2));
   assign push_flags.frame_end = frame_end;

endmodule

// ===== rtl/lmc_queue.sv =====
`timescale 1ns / 1ps
// Two-entry queue of classified pixels between front and back end.
module lmc_queue #(
   parameter int PIXEL_BITS = 10,
   parameter int SLOT_BITS  = 10
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [PIXEL_BITS-1:0]      push_pix,
   input  logic [SLOT_BITS-1:0]       push_slot,
   input  lmc_pkg::item_flags_type    push_flags,
   output logic                       pop_valid,
   input  logic                       pop_ready,
   output logic [PIXEL_BITS-1:0]      pop_pix,
   output logic [SLOT_BITS-1:0]       pop_slot,
   output lmc_pkg::item_flags_type    pop_flags,
   output lmc_pkg::queue_status_type  status
);

   logic [PIXEL_BITS-1:0]   pix_ff   [2];
   logic [SLOT_BITS-1:0]    slot_ff  [2];
   lmc_pkg::item_flags_type flags_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   logic                    do_push, do_pop;

   assign status.empty = (count_ff == 2'd0);
   assign status.full  = (count_ff == 2'd2);
   assign do_push      = push && !status.full;
   assign do_pop       = pop_ready && !status.empty;

   assign pop_valid = !status.empty;
   assign pop_pix   = pix_ff[rd_ptr_ff];
   assign pop_slot  = slot_ff[rd_ptr_ff];
   assign pop_flags = flags_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         pix_ff[wr_ptr_ff]   <= push_pix;
         slot_ff[wr_ptr_ff]  <= push_slot;
         flags_ff[wr_ptr_ff] <= push_flags;
      end
   end

endmodule

// ===== rtl/lmc_back.sv =====
`timescale 1ns / 1ps
// Back end: line stores, 3x3 window, peak test, frame count and result register.
module lmc_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 10
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  logic [PIXEL_BITS-1:0]          pop_pix,
   input  logic [$clog2(MAX_WIDTH)-1:0]   pop_slot,
   input  lmc_pkg::item_flags_type        pop_flags,
   lmc_rsp_if.source                      rsp_chan,
   output lmc_pkg::back_status_type       status
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int CB = lmc_pkg::COUNT_BITS;

   logic [PIXEL_BITS-1:0]   upper_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]   lower_mem [MAX_WIDTH];

   logic                    stage_valid_ff, stage_valid_in;
   logic [PIXEL_BITS-1:0]   stage_pix_ff;
   logic [CW-1:0]           stage_slot_ff;
   lmc_pkg::item_flags_type stage_flags_ff;
   logic [PIXEL_BITS-1:0]   top_ff, mid_ff;

   logic [PIXEL_BITS-1:0]   win_ff [9];
   logic [PIXEL_BITS-1:0]   win_in [9];
   logic [CB-1:0]           count_ff, count_in, count_sum;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [lmc_pkg::PEAK_BITS-1:0] rsp_count_ff;

   logic                    retire, pop, is_peak;

   // a frame result may only retire once the result register is free
   assign retire = stage_valid_ff &&
                   !(stage_flags_ff.frame_end && rsp_valid_ff && !rsp_chan.ready);
   assign pop_ready   = !stage_valid_ff || retire;
   assign pop         = pop_valid && pop_ready;
   assign status.busy = stage_valid_ff;
   assign status.held = stage_valid_ff && !retire;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r*3 + 0] = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = top_ff;
      win_in[5] = mid_ff;
      win_in[8] = stage_pix_ff;
   end

   always_comb begin
      is_peak = stage_flags_ff.centre;
      for (int k = 0; k < 9; k++) begin
         if (k != 4 && !(win_in[4] > win_in[k])) begin
            is_peak = 1'b0;
         end
      end
   end

   // saturate rather than wrap
   assign count_sum = (is_peak && count_ff != lmc_pkg::COUNT_MAX) ?
                      count_ff + CB'(1) : count_ff;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (pop) begin
         stage_valid_in = 1'b1;
      end else if (retire) begin
         stage_valid_in = 1'b0;
      end
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (retire) begin
         if (stage_flags_ff.frame_end) begin
            count_in     = '0;
            rsp_valid_in = 1'b1;
         end else begin
            count_in = count_sum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         count_ff       <= '0;
         for (int k = 0; k < 9; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         count_ff       <= count_in;
         if (retire) begin
            for (int k = 0; k < 9; k++) begin
               win_ff[k] <= win_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         stage_pix_ff   <= pop_pix;
         stage_slot_ff  <= pop_slot;
         stage_flags_ff <= pop_flags;
      end
      if (retire && stage_flags_ff.frame_end) begin
         rsp_count_ff <= count_sum[lmc_pkg::PEAK_BITS-1:0];
      end
   end

   // line stores: read one item ahead, write back as the item retires
   always_ff @(posedge clock) begin
      if (pop) begin
         top_ff <= upper_mem[pop_slot];
         mid_ff <= lower_mem[pop_slot];
      end
      if (retire) begin
         upper_mem[stage_slot_ff] <= mid_ff;
         lower_mem[stage_slot_ff] <= stage_pix_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.peak_count = rsp_count_ff;

endmodule

// ===== rtl/local_maximum_counter_3x3_core.sv =====
`timescale 1ns / 1ps
// Top level of the 3x3 strict local maximum counter.
//
// Pixels stream in raster order, one per clock when both sides are ready; a
// frame of frame_width x frame_height pixels (each clamped to 3..MAX_WIDTH and
// 3..1024) yields one transaction on the response channel carrying the number
// of interior pixels strictly greater than all eight neighbours. The front end
// tracks the raster position and classifies each pixel into a two-entry queue;
// the back end reads both line stores one item ahead of the window update and
// writes them back as the pixel retires, so the throughput of one pixel per
// cycle while no frame result is held is set by that read-then-write line
// store pipeline. Only a frame result that finds the result register still
// occupied holds the back end. The line stores need no clearing pass after
// reset. Size registers sit at byte addresses 0 (width) and 4 (height) and are
// to be written only while idle; the block itself does not enforce this.
module local_maximum_counter_3x3_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int PIXEL_BITS = 10
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lmc_req_if.sink                              req_chan,
   lmc_rsp_if.source                            rsp_chan,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lmc_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [lmc_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [lmc_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [lmc_pkg::CFG_BITS-1:0] width_ff, width_in;
   logic [lmc_pkg::CFG_BITS-1:0] height_ff, height_in;
   lmc_pkg::reg_index_type       reg_sel;
   logic                         csr_write;

   logic                         push;
   logic [PIXEL_BITS-1:0]        push_pix;
   logic [CW-1:0]                push_slot;
   lmc_pkg::item_flags_type      push_flags;
   logic                         pop_valid, pop_ready;
   logic [PIXEL_BITS-1:0]        pop_pix;
   logic [CW-1:0]                pop_slot;
   lmc_pkg::item_flags_type      pop_flags;
   lmc_pkg::queue_status_type    queue_st;
   lmc_pkg::back_status_type     back_st;

   assign csr_pready = 1'b1;
   assign reg_sel    = lmc_pkg::reg_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_write) begin
         unique case (reg_sel)
            lmc_pkg::REG_FRAME_WIDTH:  width_in  = csr_pwdata[lmc_pkg::CFG_BITS-1:0];
            lmc_pkg::REG_FRAME_HEIGHT: height_in = csr_pwdata[lmc_pkg::CFG_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         lmc_pkg::REG_FRAME_WIDTH:
            csr_prdata = lmc_pkg::CSR_DATA_BITS'(width_ff);
         lmc_pkg::REG_FRAME_HEIGHT:
            csr_prdata = lmc_pkg::CSR_DATA_BITS'(height_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= lmc_pkg::SIZE_RESET;
         height_ff <= lmc_pkg::SIZE_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   lmc_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .queue_full   (queue_st.full),
      .push         (push),
      .push_pix     (push_pix),
      .push_slot    (push_slot),
      .push_flags   (push_flags)
   );

   lmc_queue #(
      .PIXEL_BITS (PIXEL_BITS),
      .SLOT_BITS  (CW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_pix   (push_pix),
      .push_slot  (push_slot),
      .push_flags (push_flags),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_pix    (pop_pix),
      .pop_slot   (pop_slot),
      .pop_flags  (pop_flags),
      .status     (queue_st)
   );

   lmc_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_pix   (pop_pix),
      .pop_slot  (pop_slot),
      .pop_flags (pop_flags),
      .rsp_chan  (rsp_chan),
      .status    (back_st)
   );

   // reset empties the queue and the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> (queue_st.empty && !rsp_chan.valid && !back_st.busy))
      else $error("state not cleared by reset");

   // the back end only holds while a frame result waits to be taken
   a_hold_cause: assert property (@(posedge clock) disable iff (reset)
      back_st.held |-> (rsp_chan.valid && !rsp_chan.ready))
      else $error("back end held without a stalled result");

   // once a result is taken, the next frame result cannot already be blocked
   a_drain_release: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> !back_st.held)
      else $error("back end held right after a result transaction");

endmodule

// ===== sim/tb_local_maximum_counter_3x3_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the 3x3 strict local maximum counter.
module tb_local_maximum_counter_3x3_core;

   localparam int MAX_W = 1024;
   localparam int DRAIN_CYCLES = 8;
   localparam int LONG_HOLD_CYCLES = 400;

   typedef enum {
      FILL_UNIFORM,
      FILL_LOW_RANGE,
      FILL_CHECKER,
      FILL_FLAT
   } fill_style_type;

   logic clock;
   logic reset;

   lmc_req_if req_bus ();
   lmc_rsp_if rsp_bus ();

   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [lmc_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [lmc_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [lmc_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                              csr_pready;

   local_maximum_counter_3x3_core #(
      .MAX_WIDTH  (MAX_W),
      .PIXEL_BITS (lmc_pkg::IN_BITS)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Pending pixels and the peak counts still owed by the block.
   logic [lmc_pkg::IN_BITS-1:0]   pixel_queue [$];
   logic [lmc_pkg::PEAK_BITS-1:0] expected_counts [$];

   int error_count = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token = 0;
   int hold_seen = 0;
   int hold_left = 0;

   // Shadow of the raster window state.
   logic [lmc_pkg::IN_BITS-1:0]    shadow_upper [MAX_W];
   logic [lmc_pkg::IN_BITS-1:0]    shadow_lower [MAX_W];
   logic [lmc_pkg::IN_BITS-1:0]    shadow_window [9];
   int unsigned                    shadow_col;
   int unsigned                    shadow_row;
   logic [lmc_pkg::COUNT_BITS-1:0] shadow_peaks;
   logic [lmc_pkg::CFG_BITS-1:0]   width_reg;
   logic [lmc_pkg::CFG_BITS-1:0]   height_reg;

   function automatic int unsigned clamp_size(input logic [lmc_pkg::CFG_BITS-1:0] raw,
                                              input int unsigned top);
      if (raw < 3) return 3;
      if (raw > top) return top;
      return raw;
   endfunction

   // Advance the shadow window by one pixel; queue a count at frame end.
   task automatic count_peak_pixel(input logic [lmc_pkg::IN_BITS-1:0] pix);
      int unsigned w, h, slot, r, k;
      logic [lmc_pkg::IN_BITS-1:0] top_val, mid_val;
      logic peak, row_end, frame_end;
      w = clamp_size(width_reg, MAX_W);
      h = clamp_size(height_reg, lmc_pkg::HEIGHT_LIMIT);
      slot = (shadow_col < MAX_W) ? shadow_col : MAX_W - 1;
      top_val = shadow_upper[slot];
      mid_val = shadow_lower[slot];
      for (r = 0; r < 3; r++) begin
         shadow_window[r*3]   = shadow_window[r*3+1];
         shadow_window[r*3+1] = shadow_window[r*3+2];
      end
      shadow_window[2] = top_val;
      shadow_window[5] = mid_val;
      shadow_window[8] = pix;
      shadow_upper[slot] = mid_val;
      shadow_lower[slot] = pix;
      if (shadow_row >= 2 && shadow_col >= 2) begin
         peak = 1'b1;
         for (k = 0; k < 9; k++) begin
            if (k != 4 && !(shadow_window[4] > shadow_window[k])) peak = 1'b0;
         end
         if (peak && shadow_peaks != lmc_pkg::COUNT_MAX) begin
            shadow_peaks = shadow_peaks + 1'b1;
         end
      end
      row_end = (shadow_col + 1 >= w);
      frame_end = row_end && (shadow_row + 1 >= h);
      if (frame_end) begin
         expected_counts.push_back(shadow_peaks[lmc_pkg::PEAK_BITS-1:0]);
         shadow_peaks = '0;
         shadow_col = 0;
         shadow_row = 0;
      end else if (row_end) begin
         shadow_col = 0;
         shadow_row = shadow_row + 1;
      end else begin
         shadow_col = shadow_col + 1;
      end
   endtask

   // Pixel driver: hold the item until accepted, idle at random between items.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.pixel_value <= '0;
      end else begin
         if (req_bus.valid && req_bus.ready) count_peak_pixel(req_bus.pixel_value);
         if (!req_bus.valid || req_bus.ready) begin
            if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_bus.valid <= 1'b1;
               req_bus.pixel_value <= pixel_queue.pop_front();
            end else begin
               req_bus.valid <= 1'b0;
               req_bus.pixel_value <= lmc_pkg::IN_BITS'($urandom);
            end
         end
      end
   end

   // Count monitor and receiver backpressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_counts.size() == 0) begin
               $error("peak_count transaction with none expected: actual %0d",
                      rsp_bus.peak_count);
               error_count++;
            end else if (rsp_bus.peak_count !== expected_counts[0]) begin
               $error("peak_count mismatch: expected %0d, actual %0d",
                      expected_counts[0], rsp_bus.peak_count);
               error_count++;
               void'(expected_counts.pop_front());
            end else begin
               void'(expected_counts.pop_front());
            end
         end
         if (hold_token != hold_seen) begin
            hold_seen = hold_token;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Write a size register, then read it back.
   task automatic write_size(input lmc_pkg::reg_index_type idx,
                             input logic [lmc_pkg::CFG_BITS-1:0] raw);
      logic [lmc_pkg::CSR_DATA_BITS-1:0] data;
      data = $urandom;
      data[lmc_pkg::CFG_BITS-1:0] = raw;
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (idx == lmc_pkg::REG_FRAME_WIDTH) width_reg = raw;
      else height_reg = raw;
      csr_pwrite <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      if (csr_prdata[lmc_pkg::CFG_BITS-1:0] !== raw) begin
         $error("prdata mismatch: expected %0d, actual %0d", raw,
                csr_prdata[lmc_pkg::CFG_BITS-1:0]);
         error_count++;
      end
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic queue_frame(input int unsigned w, input int unsigned h,
                              input fill_style_type style);
      int unsigned r, c;
      logic [lmc_pkg::IN_BITS-1:0] level;
      level = lmc_pkg::IN_BITS'($urandom);
      for (r = 0; r < h; r++) begin
         for (c = 0; c < w; c++) begin
            case (style)
               FILL_UNIFORM: pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom));
               FILL_LOW_RANGE: pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom_range(0, 3)));
               FILL_CHECKER: begin
                  if (r[0] && c[0]) begin
                     pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom_range(512, 1023)));
                  end else begin
                     pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom_range(0, 511)));
                  end
               end
               default: pixel_queue.push_back(level);
            endcase
         end
      end
   endtask

   // Wait until every pixel is taken and every count has come back.
   task automatic drain();
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_bus.valid || expected_counts.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5ms;
      $display("local_maximum_counter_3x3_core verification failed");
      $finish;
   end

   initial begin
      int unsigned i, frames, pushed, w_eff, h_eff;
      logic [lmc_pkg::CFG_BITS-1:0] raw_w, raw_h;
      fill_style_type style;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.pixel_value = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (i = 0; i < MAX_W; i++) begin
         shadow_upper[i] = '0;
         shadow_lower[i] = '0;
      end
      for (i = 0; i < 9; i++) shadow_window[i] = '0;
      shadow_col = 0;
      shadow_row = 0;
      shadow_peaks = '0;
      width_reg = lmc_pkg::SIZE_RESET;
      height_reg = lmc_pkg::SIZE_RESET;
      send_idle_pct = 35;
      recv_idle_pct = 55;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset size first, before any register write.
      queue_frame(10, 10, FILL_UNIFORM);
      drain();

      // Undersized registers clamp to 3x3: one lone peak, then a flat max frame.
      write_size(lmc_pkg::REG_FRAME_WIDTH, 11'd0);
      write_size(lmc_pkg::REG_FRAME_HEIGHT, 11'd1);
      for (i = 0; i < 9; i++) pixel_queue.push_back((i == 4) ? 10'd1023 : 10'd1022);
      for (i = 0; i < 9; i++) pixel_queue.push_back(10'd1023);
      drain();

      // Shrink width with the column already past it, then height with the row past it.
      write_size(lmc_pkg::REG_FRAME_WIDTH, 11'd6);
      write_size(lmc_pkg::REG_FRAME_HEIGHT, 11'd6);
      for (i = 0; i < 22; i++) pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom));
      drain();
      write_size(lmc_pkg::REG_FRAME_WIDTH, 11'd3);
      pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom));
      drain();
      write_size(lmc_pkg::REG_FRAME_HEIGHT, 11'd3);
      for (i = 0; i < 3; i++) pixel_queue.push_back(lmc_pkg::IN_BITS'($urandom));
      drain();

      // Long receiver hold while small frames keep coming, so the block backs up.
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_token++;
      for (i = 0; i < 30; i++) queue_frame(3, 3, FILL_UNIFORM);
      drain();

      pushed = 0;
      while (pushed < 1500) begin
         if (pushed < 500) begin
            send_idle_pct = 35;
            recv_idle_pct = 55;
         end else if (pushed < 1000) begin
            send_idle_pct = 55;
            recv_idle_pct = 35;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         raw_w = ($urandom_range(0, 9) == 0) ? lmc_pkg::CFG_BITS'($urandom_range(0, 2))
                                             : lmc_pkg::CFG_BITS'($urandom_range(3, 12));
         raw_h = ($urandom_range(0, 9) == 0) ? lmc_pkg::CFG_BITS'($urandom_range(0, 2))
                                             : lmc_pkg::CFG_BITS'($urandom_range(3, 12));
         write_size(lmc_pkg::REG_FRAME_WIDTH, raw_w);
         write_size(lmc_pkg::REG_FRAME_HEIGHT, raw_h);
         w_eff = clamp_size(raw_w, MAX_W);
         h_eff = clamp_size(raw_h, lmc_pkg::HEIGHT_LIMIT);
         frames = $urandom_range(1, 4);
         for (i = 0; i < frames; i++) begin
            style = fill_style_type'($urandom_range(0, 3));
            queue_frame(w_eff, h_eff, style);
            pushed += w_eff * h_eff;
         end
         drain();
      end

      if (error_count == 0) begin
         $display("local_maximum_counter_3x3_core verification clean");
      end else begin
         $display("local_maximum_counter_3x3_core verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/lmc_pkg.sv
rtl/lmc_intf.sv
rtl/lmc_front.sv
rtl/lmc_queue.sv
rtl/lmc_back.sv
rtl/local_maximum_counter_3x3_core.sv
sim/tb_local_maximum_counter_3x3_core.sv
